/* hdl/hpt_pkg.sv */
// Shared widths, character codes and record types of the header parameter tokenizer.
package hpt_pkg;

  localparam int OFF_W = 10;
  localparam int CH_W = 8;
  localparam int DEFAULT_MAX_FIELD_LEN = 1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [CH_W-1:0] CHAR_SEMI = 8'h3B;
  localparam logic [CH_W-1:0] CHAR_EQ = 8'h3D;
  localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [OFF_W-1:0] key_start;
    logic [OFF_W-1:0] key_len;
    logic [OFF_W-1:0] value_start;
    logic [OFF_W-1:0] value_len;
    logic ok;
    logic done_res;
  } rec_t;

  // One queue entry holds every record that one byte produces.
  typedef struct packed {
    rec_t first;
    rec_t second;
    logic two;
  } entry_t;

  typedef struct packed {
    logic valid;
    entry_t entry;
  } q_wr_t;

endpackage

/* hdl/hpt_text_if.sv */
// Input word channel: one byte of the field text with its end-of-field flag.
interface hpt_text_if;
  logic valid;
  logic ready;
  logic [hpt_pkg::CH_W-1:0] ch;
  logic end_of_field;

  modport source (output valid, output ch, output end_of_field, input ready);
  modport sink (input valid, input ch, input end_of_field, output ready);
endinterface

/* hdl/hpt_param_if.sv */
// Output word channel: one parameter record, or the error record of a field.
interface hpt_param_if;
  logic valid;
  logic ready;
  logic [hpt_pkg::OFF_W-1:0] key_start;
  logic [hpt_pkg::OFF_W-1:0] key_len;
  logic [hpt_pkg::OFF_W-1:0] value_start;
  logic [hpt_pkg::OFF_W-1:0] value_len;
  logic ok;
  logic done_res;

  modport source (output valid, output key_start, output key_len, output value_start,
                  output value_len, output ok, output done_res, input ready);
  modport sink (input valid, input key_start, input key_len, input value_start,
                input value_len, input ok, input done_res, output ready);
endinterface

/* hdl/hpt_front.sv */
// Front end: parses one byte per cycle unless full; queues each record it completes.
module hpt_front #(
  parameter int MAX_FIELD_LEN = hpt_pkg::DEFAULT_MAX_FIELD_LEN
) (
  input  logic clk,
  input  logic rst,
  hpt_text_if.sink text,
  input  logic full,
  output hpt_pkg::q_wr_t wr
);

  localparam int OFF_TOP = (1 << hpt_pkg::OFF_W) - 1;
  localparam int OFF_MAX_I = (MAX_FIELD_LEN - 1 < OFF_TOP) ? (MAX_FIELD_LEN - 1) : OFF_TOP;
  localparam logic [hpt_pkg::OFF_W-1:0] OFF_MAX = OFF_MAX_I[hpt_pkg::OFF_W-1:0];

  typedef enum logic [5:0] {
    ST_START = 6'b000001,
    ST_KLEAD = 6'b000010,
    ST_KEY   = 6'b000100,
    ST_VLEAD = 6'b001000,
    ST_VAL   = 6'b010000,
    ST_FAIL  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [hpt_pkg::OFF_W-1:0] position, position_next;
  logic [hpt_pkg::OFF_W-1:0] key_begin, key_begin_next;
  logic [hpt_pkg::OFF_W-1:0] key_stop, key_stop_next;
  logic [hpt_pkg::OFF_W-1:0] value_begin, value_begin_next;
  logic [hpt_pkg::OFF_W-1:0] value_stop, value_stop_next;

  state_t st_m;
  logic [hpt_pkg::OFF_W-1:0] nx, kb_m, ks_m, vb_m, vs_m, ks_f, vb_f, vs_f;
  logic acc, last, emit0;
  hpt_pkg::rec_t rec0, fin;

  assign text.ready = !full;
  assign acc = text.valid && text.ready;
  assign last = text.end_of_field;
  // Offsets stop at the top of their range.
  assign nx = (position == OFF_MAX) ? OFF_MAX : position + 1'b1;

  always_comb begin
    st_m = state;
    kb_m = key_begin;
    ks_m = key_stop;
    vb_m = value_begin;
    vs_m = value_stop;
    emit0 = 1'b0;
    rec0 = '0;
    unique case (state)
      ST_START: begin
        if (text.ch == hpt_pkg::CHAR_SEMI) begin
          st_m = ST_KLEAD;
          kb_m = nx; ks_m = nx; vb_m = nx; vs_m = nx;
        end else begin
          st_m = ST_FAIL;
        end
      end
      ST_KLEAD, ST_KEY: begin
        if (text.ch == hpt_pkg::CHAR_SEMI) begin
          // A key closed by a separator keeps its trailing spaces.
          emit0 = 1'b1;
          rec0.key_start = key_begin;
          rec0.key_len = position - key_begin;
          rec0.value_start = position;
          rec0.value_len = '0;
          rec0.ok = 1'b1;
          st_m = ST_KLEAD;
          kb_m = nx; ks_m = nx; vb_m = nx; vs_m = nx;
        end else if (text.ch == hpt_pkg::CHAR_EQ) begin
          vb_m = nx; vs_m = nx;
          st_m = ST_VLEAD;
        end else if (text.ch == hpt_pkg::CHAR_SPACE) begin
          if (state == ST_KLEAD) begin
            kb_m = nx; ks_m = nx;
          end
        end else begin
          ks_m = nx;
          st_m = ST_KEY;
        end
      end
      ST_VLEAD, ST_VAL: begin
        if (text.ch == hpt_pkg::CHAR_SEMI) begin
          emit0 = 1'b1;
          rec0.key_start = key_begin;
          rec0.key_len = key_stop - key_begin;
          rec0.value_start = value_begin;
          rec0.value_len = value_stop - value_begin;
          rec0.ok = 1'b1;
          st_m = ST_KLEAD;
          kb_m = nx; ks_m = nx; vb_m = nx; vs_m = nx;
        end else if (text.ch == hpt_pkg::CHAR_SPACE) begin
          if (state == ST_VLEAD) begin
            vb_m = nx; vs_m = nx;
          end
        end else begin
          vs_m = nx;
          st_m = ST_VAL;
        end
      end
      ST_FAIL: begin
        st_m = ST_FAIL;
      end
      default: begin
        st_m = state;
      end
    endcase

    // Record closed by the final byte of the field.
    ks_f = ks_m;
    vb_f = vb_m;
    vs_f = vs_m;
    if (st_m == ST_KLEAD || st_m == ST_KEY) begin
      ks_f = nx; vb_f = nx; vs_f = nx;
    end
    fin = '0;
    fin.done_res = 1'b1;
    if (st_m != ST_FAIL) begin
      fin.key_start = kb_m;
      fin.key_len = ks_f - kb_m;
      fin.value_start = vb_f;
      fin.value_len = vs_f - vb_f;
      fin.ok = 1'b1;
    end

    wr.valid = acc && (emit0 || last);
    wr.entry.first = emit0 ? rec0 : fin;
    wr.entry.second = fin;
    wr.entry.two = emit0 && last;

    if (last) begin
      state_next = ST_START;
      position_next = '0;
      key_begin_next = '0;
      key_stop_next = '0;
      value_begin_next = '0;
      value_stop_next = '0;
    end else begin
      state_next = st_m;
      position_next = nx;
      key_begin_next = kb_m;
      key_stop_next = ks_m;
      value_begin_next = vb_m;
      value_stop_next = vs_m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      position <= '0;
      key_begin <= '0;
      key_stop <= '0;
      value_begin <= '0;
      value_stop <= '0;
    end else if (acc) begin
      state <= state_next;
      position <= position_next;
      key_begin <= key_begin_next;
      key_stop <= key_stop_next;
      value_begin <= value_begin_next;
      value_stop <= value_stop_next;
    end
  end

`ifndef SYNTHESIS
  a_field_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && last) |=> (state == ST_START && position == '0))
    else $error("parser did not return to field start after the final byte");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position <= OFF_MAX)
    else $error("position ran past its saturation limit");
`endif

endmodule

/* hdl/hpt_queue.sv */
// Short record queue between the parser and the output stage.
module hpt_queue (
  input  logic clk,
  input  logic rst,
  input  hpt_pkg::q_wr_t wr,
  output logic full,
  output logic rd_valid,
  output hpt_pkg::entry_t rd_entry,
  input  logic pop
);

  hpt_pkg::entry_t mem [hpt_pkg::QUEUE_DEPTH];
  logic [hpt_pkg::QUEUE_AW-1:0] wp, rp;
  logic [hpt_pkg::QUEUE_AW:0] count;
  logic do_pop;

  localparam logic [hpt_pkg::QUEUE_AW:0] DEPTH = hpt_pkg::QUEUE_DEPTH[hpt_pkg::QUEUE_AW:0];

  assign full = (count == DEPTH);
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rp];
  assign do_pop = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wp] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr.valid) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + {{hpt_pkg::QUEUE_AW{1'b0}}, wr.valid}
                     - {{hpt_pkg::QUEUE_AW{1'b0}}, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr.valid)
    else $error("record written into a full queue");
`endif

endmodule

/* hdl/hpt_back.sv */
// Output stage: a register issues queued records one word per cycle unless param stalls.
module hpt_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  hpt_pkg::entry_t q_entry,
  output logic pop,
  hpt_param_if.source param
);

  logic out_valid;
  hpt_pkg::rec_t out_rec;
  logic pend_valid;
  hpt_pkg::rec_t pend_rec;
  logic load;

  assign load = !out_valid || param.ready;
  assign pop = load && !pend_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        pend_valid <= q_entry.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_rec <= pend_rec;
      end else if (q_valid) begin
        out_rec <= q_entry.first;
        pend_rec <= q_entry.second;
      end
    end
  end

  assign param.valid = out_valid;
  assign param.key_start = out_rec.key_start;
  assign param.key_len = out_rec.key_len;
  assign param.value_start = out_rec.value_start;
  assign param.value_len = out_rec.value_len;
  assign param.ok = out_rec.ok;
  assign param.done_res = out_rec.done_res;

`ifndef SYNTHESIS
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("second record held while the output register is empty");
`endif

endmodule

/* hdl/header_param_tokenizer.sv */
// Top level of the header parameter tokenizer: parser, record queue and output stage.
//
// The block reads a header field's parameter list (";key=value;key2;...") one byte per
// word on the text channel, the final byte flagged by end_of_field, and writes one word
// on the param channel for each parameter found: start offset and length of the key and
// of the value. Spaces after ';' and '=' are skipped and spaces before '=' are trimmed;
// a key closed without '=' keeps its trailing spaces and gets an empty value that starts
// just past it. A ';' as the final byte adds an empty parameter, and a field that does
// not open with ';' gives one word with ok low at its final byte. done_res marks the
// last word of each field. Offsets stop at min(MAX_FIELD_LEN - 1, 1023). The parser
// takes one byte every cycle with no gaps between fields; each word is written into the
// queue and then into the output register that drives param. A byte that closes two
// parameters at once yields two words, which the output stage issues one after the
// other; a four-entry queue between the parser and the output stage absorbs that and
// any stall on param, so text is only held off once the queue has filled.
module header_param_tokenizer #(
  parameter int MAX_FIELD_LEN = hpt_pkg::DEFAULT_MAX_FIELD_LEN
) (
  input  logic clk,
  input  logic rst,
  hpt_text_if.sink text,
  hpt_param_if.source param
);

  hpt_pkg::q_wr_t q_wr;
  hpt_pkg::entry_t q_entry;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // The parser classifies each byte and closes records as separators arrive.
  hpt_front #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .text(text),
    .full(q_full),
    .wr(q_wr)
  );

  // Each queue entry carries all records of one byte, so one write per byte suffices.
  hpt_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr(q_wr),
    .full(q_full),
    .rd_valid(q_valid),
    .rd_entry(q_entry),
    .pop(q_pop)
  );

  // The output stage splits two-record entries and holds a word while param stalls.
  hpt_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_entry(q_entry),
    .pop(q_pop),
    .param(param)
  );

endmodule

/* sim/hpt_checker.sv */
// Checker for the header parameter tokenizer: predicts records from accepted bytes and compares.
module hpt_checker #(
  parameter int MAX_FIELD_LEN = hpt_pkg::DEFAULT_MAX_FIELD_LEN
) (
  input  logic clk,
  input  logic rst,
  hpt_text_if  text,
  hpt_param_if param,
  output int   fail_count,
  output int   backlog,
  output int   checked,
  output int   error_recs
);
  timeunit 1ns;
  timeprecision 1ps;
  import hpt_pkg::*;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_KEY_LEAD,
    SCAN_KEY,
    SCAN_VAL_LEAD,
    SCAN_VAL
  } scan_phase_t;

  localparam int OFF_TOP =
      (MAX_FIELD_LEN - 1 < (1 << OFF_W) - 1) ? MAX_FIELD_LEN - 1 : (1 << OFF_W) - 1;

  scan_phase_t scan_ph;
  int cursor;
  int key_lo;
  int key_hi;
  int val_lo;
  int val_hi;
  logic no_lead;

  rec_t expected_params[$];
  int fails = 0;
  int pending = 0;
  int compared = 0;
  int lead_errors = 0;

  assign fail_count = fails;
  assign backlog = pending;
  assign checked = compared;
  assign error_recs = lead_errors;

  function automatic int clip(input int v);
    return (v > OFF_TOP) ? OFF_TOP : v;
  endfunction

  function automatic void clear_scan();
    scan_ph = SCAN_START;
    cursor = 0;
    key_lo = 0;
    key_hi = 0;
    val_lo = 0;
    val_hi = 0;
    no_lead = 1'b0;
  endfunction

  function automatic void open_param(input int at);
    key_lo = at;
    key_hi = at;
    val_lo = at;
    val_hi = at;
    scan_ph = SCAN_KEY_LEAD;
  endfunction

  function automatic void queue_param(input logic ok, input logic done);
    rec_t r;
    r = '0;
    if (ok) begin
      r.key_start = OFF_W'(key_lo);
      r.key_len = OFF_W'(key_hi - key_lo);
      r.value_start = OFF_W'(val_lo);
      r.value_len = OFF_W'(val_hi - val_lo);
    end
    r.ok = ok;
    r.done_res = done;
    expected_params.push_back(r);
  endfunction

  // Advances the scanner by one byte and queues the records that byte completes.
  function automatic void tokenize_byte(input logic [CH_W-1:0] c, input logic last);
    int here;
    int after;
    here = clip(cursor);
    after = clip(here + 1);
    if (!no_lead) begin
      case (scan_ph)
        SCAN_START: begin
          if (c == CHAR_SEMI) open_param(after);
          else no_lead = 1'b1;
        end
        SCAN_KEY_LEAD, SCAN_KEY: begin
          if (c == CHAR_SEMI) begin
            // A key closed by ';' keeps its trailing spaces.
            key_hi = here;
            val_lo = here;
            val_hi = here;
            queue_param(1'b1, 1'b0);
            open_param(after);
          end else if (c == CHAR_EQ) begin
            val_lo = after;
            val_hi = after;
            scan_ph = SCAN_VAL_LEAD;
          end else if (c == CHAR_SPACE) begin
            if (scan_ph == SCAN_KEY_LEAD) begin
              key_lo = after;
              key_hi = after;
            end
          end else begin
            key_hi = after;
            scan_ph = SCAN_KEY;
          end
        end
        default: begin
          if (c == CHAR_SEMI) begin
            queue_param(1'b1, 1'b0);
            open_param(after);
          end else if (c == CHAR_SPACE) begin
            if (scan_ph == SCAN_VAL_LEAD) begin
              val_lo = after;
              val_hi = after;
            end
          end else begin
            val_hi = after;
            scan_ph = SCAN_VAL;
          end
        end
      endcase
    end
    if (last) begin
      if (no_lead) begin
        queue_param(1'b0, 1'b1);
      end else begin
        if (scan_ph == SCAN_KEY_LEAD || scan_ph == SCAN_KEY) begin
          key_hi = after;
          val_lo = after;
          val_hi = after;
        end
        queue_param(1'b1, 1'b1);
      end
      clear_scan();
    end else begin
      cursor = after;
    end
  endfunction

  function automatic void check_field(input string name, input logic [OFF_W-1:0] want,
                                      input logic [OFF_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  function automatic void compare_param();
    rec_t want;
    if (expected_params.size() == 0) begin
      $display("%0t: unexpected record, expected none, got key %0d/%0d value %0d/%0d ok %0b",
               $time, param.key_start, param.key_len, param.value_start, param.value_len,
               param.ok);
      fails++;
    end else begin
      want = expected_params.pop_front();
      check_field("key_start", want.key_start, param.key_start);
      check_field("key_len", want.key_len, param.key_len);
      check_field("value_start", want.value_start, param.value_start);
      check_field("value_len", want.value_len, param.value_len);
      check_field("ok", OFF_W'(want.ok), OFF_W'(param.ok));
      check_field("done_res", OFF_W'(want.done_res), OFF_W'(param.done_res));
      compared++;
      if (!want.ok) lead_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_params.delete();
    end else begin
      if (text.valid && text.ready) tokenize_byte(text.ch, text.end_of_field);
      if (param.valid && param.ready) compare_param();
    end
    pending = expected_params.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top: feeds parameter-list bytes to the tokenizer under changing back-pressure.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpt_pkg::*;

  typedef logic [CH_W-1:0] text_t[$];

  logic clk;
  logic rst;

  // The receiver's ready is redrawn every cycle in its own process; hold_off and
  // stall_pct are written with nonblocking assignments so that process always sees
  // the values from before the edge.
  logic hold_off = 1'b0;
  int stall_pct = 0;
  int src_idle_pct = 0;

  int bytes_sent = 0;
  int fields_sent = 0;
  int longest_field = 0;

  int fail_count;
  int backlog;
  int checked;
  int error_recs;

  hpt_text_if text_ch();
  hpt_param_if param_ch();

  header_param_tokenizer u_top (
    .clk(clk),
    .rst(rst),
    .text(text_ch),
    .param(param_ch)
  );

  hpt_checker u_chk (
    .clk(clk),
    .rst(rst),
    .text(text_ch),
    .param(param_ch),
    .fail_count(fail_count),
    .backlog(backlog),
    .checked(checked),
    .error_recs(error_recs)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: ready low while a hold-off is running, otherwise low in stall_pct
  // cycles out of a hundred.
  initial begin
    param_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      param_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // A long receiver stall while the sender keeps offering bytes: the record queue
  // inside the block fills and the text channel has to be held off.
  task automatic hold_off_stretch(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // Offers one word and returns at the edge that accepts it. An idle cycle only ever
  // lowers valid, and valid is only raised when a new word goes out, so valid never
  // gets two assignments in one step.
  task automatic send_word(input logic [CH_W-1:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.ch <= c;
    text_ch.end_of_field <= last;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_field(input text_t f);
    foreach (f[i]) send_word(f[i], i == f.size() - 1);
    fields_sent++;
    if (f.size() > longest_field) longest_field = f.size();
  endtask

  function automatic text_t from_text(input string s);
    text_t f;
    f = {};
    for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
    return f;
  endfunction

  // Key bytes are mostly letters and digits, with an occasional inner space.
  function automatic logic [CH_W-1:0] key_byte();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h61 + CH_W'($urandom_range(25));
    if (r < 90) return 8'h30 + CH_W'($urandom_range(9));
    return CHAR_SPACE;
  endfunction

  // Value bytes are letters, spaces (leading, inner and trailing) and any byte at
  // all, so that every bit of ch gets exercised and the odd ';' or '=' turns up.
  function automatic logic [CH_W-1:0] value_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'h61 + CH_W'($urandom_range(25));
    if (r < 75) return CHAR_SPACE;
    return CH_W'($urandom_range(255));
  endfunction

  // Builds one field. Most fields are well formed: a leading ';', then parameters
  // with random spacing, keys with or without '=', values of random length and
  // sometimes a trailing ';'. The rest are pure noise or fields that miss the
  // leading separator. A nonzero min_len forces a well-formed field at least that
  // long.
  task automatic build_field(output text_t f, input int min_len, input int max_val);
    int shape;
    int n_params;
    f = {};
    shape = (min_len > 0) ? 9 : $urandom_range(9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 6)) f.push_back(CH_W'($urandom_range(255)));
    end else if (shape == 1) begin
      f.push_back(key_byte());
      repeat ($urandom_range(0, 6)) f.push_back(value_byte());
    end else begin
      f.push_back(CHAR_SEMI);
      n_params = $urandom_range(1, 4);
      for (int i = 0; i < n_params || f.size() < min_len; i++) begin
        if (i > 0) f.push_back(CHAR_SEMI);
        repeat ($urandom_range(0, 2)) f.push_back(CHAR_SPACE);
        repeat ($urandom_range(0, 5)) f.push_back(key_byte());
        repeat ($urandom_range(0, 2)) f.push_back(CHAR_SPACE);
        if ($urandom_range(3) != 0) begin
          f.push_back(CHAR_EQ);
          repeat ($urandom_range(0, 2)) f.push_back(CHAR_SPACE);
          repeat ($urandom_range(0, max_val)) f.push_back(value_byte());
        end
      end
      if ($urandom_range(3) == 0) f.push_back(CHAR_SEMI);
    end
  endtask

  task automatic run_random(input int n_bytes);
    text_t f;
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_field(f, 0, 6);
      send_field(f);
    end
  endtask

  initial begin
    text_t f;
    rst <= 1'b1;
    text_ch.valid <= 1'b0;
    text_ch.ch <= '0;
    text_ch.end_of_field <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed fields, sent back to back with no idling.
    // A lone ';' is a trailing separator on an empty list: one empty parameter.
    send_field(from_text(";"));
    // No leading separator, with the two extreme byte values.
    f = {8'hFF, 8'h00};
    send_field(f);
    // Skipped and trimmed spaces around the key, a trimmed value, a key without a
    // value, and a final ';' that closes one parameter and adds an empty one.
    send_field(from_text("; k =v ;x;"));
    // A key without '=' keeps its trailing space; then an empty key with a value.
    send_field(from_text(";ab ;= ~"));
    // Two separators: an empty parameter closed, then an empty one added.
    send_field(from_text(";;"));
    // Missing separator where the later bytes look well formed.
    send_field(from_text("x=1"));

    // No idling on either side, with one long receiver stall at the start.
    fork
      hold_off_stretch(60);
    join_none
    run_random(220);

    // Sender idle most of the time.
    src_idle_pct = 69;
    run_random(220);

    // Receiver stalling most of the time.
    src_idle_pct = 0;
    stall_pct <= 69;
    run_random(220);

    // Both sides idling now and then.
    src_idle_pct = 28;
    stall_pct <= 28;
    run_random(220);

    text_ch.valid <= 1'b0;

    // Drain: the backlog is read between edges, then a few more cycles catch any
    // record the block might send without a matching byte.
    do @(negedge clk); while (backlog != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d fields over four idling phases; longest field %0d bytes.",
             bytes_sent, fields_sent, longest_field);
    $display("Compared %0d records, %0d of them for fields without a leading separator.",
             checked, error_recs);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, many times the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d records still expected.", backlog);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
